// File: design/aldk_pkg.sv
// Shared types and constants for the ADC ladder key decoder.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none

package aldk_pkg;

	// item kinds
	localparam logic [1:0] KIND_SAMPLE = 2'd0;
	localparam logic [1:0] KIND_MAP    = 2'd1;
	localparam logic [1:0] KIND_TICK   = 2'd2;
	localparam logic [1:0] KIND_RSVD   = 2'd3;

	// result events
	localparam logic [1:0] EV_PRESS   = 2'd0;
	localparam logic [1:0] EV_REPEAT  = 2'd1;
	localparam logic [1:0] EV_RELEASE = 2'd2;
	localparam logic [1:0] EV_RELEARN = 2'd3;

	// configuration register indexes
	localparam logic [1:0] CFG_REF  = 2'd0;
	localparam logic [1:0] CFG_ADJ  = 2'd1;
	localparam logic [1:0] CFG_KEYS = 2'd2;
	localparam logic [1:0] CFG_REL  = 2'd3;

	localparam int CFG_W   = 16;
	localparam int PROD_W  = 19;
	localparam int DIV_W   = 9;
	localparam int MV_W    = 20;
	localparam int CODE_W  = 10;
	localparam int ENTRY_W = 2 * MV_W + CODE_W;

	localparam logic [10:0]       REF_MAX    = 11'd2000;
	localparam logic [10:0]       REF_RST    = 11'd2000;
	localparam logic [7:0]        ADJ_RST    = 8'd1;
	localparam logic [15:0]       REL_RST    = 16'd200;
	localparam logic [7:0]        IDLE_FULL  = 8'hFF;
	localparam logic [DIV_W-1:0]  FIXED_DIV  = 9'd260;
	localparam logic [3:0]        MISS_LIMIT = 4'd10;
	localparam logic [4:0]        DIV_STEPS  = 5'd19;

	typedef struct packed {
		logic load;
		logic mul;
		logic div_step;
		logic walk_start;
		logic walk_step;
		logic decide;
	} cmd_t;

	typedef struct packed {
		logic div_done;
		logic walk_done;
		logic out_free;
	} sts_t;

endpackage

`default_nettype wire

// File: design/aldk_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; holds the key map for the datapath.
`default_nettype none

module aldk_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                                   clk,
	input  wire logic                                   we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                       wdata,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// File: design/aldk_ctrl.sv
// Sequencing state machine of the key decoder: accept, multiply, divide, map walk, decide.
// Uses aldk_pkg for item kinds and the command and status structs.
`default_nettype none

module aldk_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           item_valid,
	input  wire logic [1:0]     item_kind,
	output logic                item_stall,
	output aldk_pkg::cmd_t      cmd,
	input  wire aldk_pkg::sts_t sts
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV,
		ST_WALK,
		ST_DECIDE
	} state_t;

	state_t state_q;

	assign item_stall = (state_q != ST_IDLE);

	always_comb begin
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				cmd.load = item_valid;
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
			end
			ST_DIV: begin
				cmd.div_step   = !sts.div_done;
				cmd.walk_start = sts.div_done;
			end
			ST_WALK: begin
				cmd.walk_step = 1'b1;
			end
			ST_DECIDE: begin
				cmd.decide = sts.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (item_valid) begin
						case (item_kind)
							aldk_pkg::KIND_SAMPLE: state_q <= ST_MUL;
							aldk_pkg::KIND_TICK:   state_q <= ST_DECIDE;
							default:               state_q <= ST_IDLE;
						endcase
					end
				end
				ST_MUL: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (sts.div_done) begin
						state_q <= ST_WALK;
					end
				end
				ST_WALK: begin
					if (sts.walk_done) begin
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					if (sts.out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// File: design/aldk_dp.sv
// Datapath of the key decoder: config registers, scaler, serial divider, map walk,
// press/release state and the result register. Uses aldk_pkg and aldk_ram.
`default_nettype none

module aldk_dp #(
	parameter int MAP_ENTRIES = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire aldk_pkg::cmd_t                cmd,
	output aldk_pkg::sts_t                     sts,
	input  wire logic                          cfg_we,
	input  wire logic [1:0]                    cfg_index,
	input  wire logic [aldk_pkg::CFG_W-1:0]    cfg_data,
	input  wire logic [1:0]                    kind,
	input  wire logic [7:0]                    sample,
	input  wire logic [3:0]                    entry_index,
	input  wire logic [aldk_pkg::MV_W-1:0]     entry_min,
	input  wire logic [aldk_pkg::MV_W-1:0]     entry_max,
	input  wire logic [aldk_pkg::CODE_W-1:0]   entry_code,
	output logic                               res_valid,
	input  wire logic                          res_stall,
	output logic [1:0]                         event_res,
	output logic [aldk_pkg::CODE_W-1:0]        code_res,
	output logic [3:0]                         key_index
);

	localparam int IW = (MAP_ENTRIES > 1) ? $clog2(MAP_ENTRIES) : 1;
	localparam int CW = $clog2(MAP_ENTRIES + 1);
	localparam int MV = aldk_pkg::MV_W;
	localparam int CD = aldk_pkg::CODE_W;
	localparam int PW = aldk_pkg::PROD_W;
	localparam int DW = aldk_pkg::DIV_W;

	// configuration
	logic [10:0] ref_q;
	logic [7:0]  adj_q;
	logic [4:0]  keys_q;
	logic [15:0] rel_q;

	// item and decode state
	logic [1:0]  kind_q;
	logic [7:0]  sample_q;
	logic [1:0]  streak_cnt_q;
	logic        streak_vld_q;
	logic [IW-1:0] streak_idx_q;
	logic [3:0]  miss_q;
	logic [7:0]  idle_q;
	logic        held_q;
	logic [CD-1:0] held_code_q;
	logic [15:0] count_q;

	// divider
	logic [PW-1:0] quo_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] div_q;
	logic [4:0]    dcnt_q;

	// map walk
	logic [CW-1:0] addr_q;
	logic          vld_s1;
	logic [IW-1:0] idx_s1;
	logic          hit_q;
	logic [IW-1:0] hit_idx_q;
	logic [CD-1:0] hit_code_q;

	logic [aldk_pkg::ENTRY_W-1:0] rd_data;
	logic                          ram_we;

	// result register
	logic          res_valid_q;

	logic [10:0]   ref_eff;
	logic [DW-1:0] div_eff;
	logic [15:0]   rel_eff;
	logic [CW-1:0] n_eff;
	logic [PW-1:0] prod;
	logic [DW:0]   rem_sh;
	logic          rem_ge;
	logic [DW:0]   rem_sub;
	logic [MV-1:0] mv;
	logic [MV-1:0] rd_min;
	logic [MV-1:0] rd_max;
	logic          hit_now;

	logic          res_load;
	logic [1:0]    res_ev;
	logic [CD-1:0] res_code;
	logic [3:0]    res_idx;
	logic [3:0]    miss_nx;
	logic [15:0]   count_dec;
	logic          same;
	logic [1:0]    streak_nx;

	always_comb begin
		ref_eff = (ref_q > aldk_pkg::REF_MAX) ? aldk_pkg::REF_MAX : ref_q;
		if (idle_q == aldk_pkg::IDLE_FULL) begin
			div_eff = aldk_pkg::FIXED_DIV;
		end else if (adj_q == 8'd0) begin
			div_eff = DW'(1);
		end else begin
			div_eff = DW'(adj_q);
		end
		rel_eff = (rel_q == 16'd0) ? 16'd1 : rel_q;
		n_eff   = (32'(keys_q) > MAP_ENTRIES) ? CW'(MAP_ENTRIES) : CW'(keys_q);
		prod    = PW'(sample_q) * PW'(ref_eff);
		rem_sh  = {rem_q, quo_q[PW-1]};
		rem_ge  = rem_sh >= {1'b0, div_q};
		rem_sub = rem_sh - {1'b0, div_q};
		mv      = MV'(quo_q);
	end

	assign ram_we = cmd.load && (kind == aldk_pkg::KIND_MAP) && (32'(entry_index) < MAP_ENTRIES);

	aldk_ram #(
		.WIDTH (aldk_pkg::ENTRY_W),
		.DEPTH (MAP_ENTRIES)
	) u_map (
		.clk   (clk),
		.we    (ram_we),
		.waddr (IW'(entry_index)),
		.wdata ({entry_min, entry_max, entry_code}),
		.raddr (addr_q[IW-1:0]),
		.rdata (rd_data)
	);

	assign rd_min  = rd_data[2*MV+CD-1 -: MV];
	assign rd_max  = rd_data[MV+CD-1 -: MV];
	assign hit_now = vld_s1 && (mv >= rd_min) && (mv <= rd_max);

	assign sts.div_done  = (dcnt_q == 5'd0);
	assign sts.walk_done = hit_now || ((addr_q == n_eff) && !vld_s1);
	assign sts.out_free  = !res_valid_q || !res_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_q  <= aldk_pkg::REF_RST;
			adj_q  <= aldk_pkg::ADJ_RST;
			keys_q <= 5'd0;
			rel_q  <= aldk_pkg::REL_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				aldk_pkg::CFG_REF:  ref_q  <= cfg_data[10:0];
				aldk_pkg::CFG_ADJ:  adj_q  <= cfg_data[7:0];
				aldk_pkg::CFG_KEYS: keys_q <= cfg_data[4:0];
				aldk_pkg::CFG_REL:  rel_q  <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// latch item, multiply, divide one quotient bit per cycle
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q   <= kind;
			sample_q <= sample;
		end
		if (cmd.mul) begin
			quo_q  <= prod;
			rem_q  <= '0;
			div_q  <= div_eff;
			dcnt_q <= aldk_pkg::DIV_STEPS;
		end else if (cmd.div_step) begin
			quo_q  <= {quo_q[PW-2:0], rem_ge};
			rem_q  <= rem_ge ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
			dcnt_q <= dcnt_q - 5'd1;
		end
	end

	// walk the map: issue one read a cycle, compare the previous read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q <= '0;
			vld_s1 <= 1'b0;
			idx_s1 <= '0;
			hit_q  <= 1'b0;
		end else if (cmd.walk_start) begin
			addr_q <= '0;
			vld_s1 <= 1'b0;
			hit_q  <= 1'b0;
		end else if (cmd.walk_step) begin
			if (addr_q < n_eff) begin
				addr_q <= addr_q + CW'(1);
				vld_s1 <= 1'b1;
				idx_s1 <= addr_q[IW-1:0];
			end else begin
				vld_s1 <= 1'b0;
			end
			if (hit_now) begin
				hit_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.walk_step && hit_now) begin
			hit_idx_q  <= idx_s1;
			hit_code_q <= rd_data[CD-1:0];
		end
	end

	always_comb begin
		res_load  = 1'b0;
		res_ev    = aldk_pkg::EV_PRESS;
		res_code  = '0;
		res_idx   = 4'd0;
		miss_nx   = miss_q + 4'd1;
		count_dec = count_q - 16'd1;
		same      = streak_vld_q && (streak_idx_q == hit_idx_q);
		streak_nx = same ? (streak_cnt_q + 2'd1) : 2'd0;
		case (kind_q)
			aldk_pkg::KIND_TICK: begin
				if ((count_q != 16'd0) && (count_dec == 16'd0)) begin
					res_load = 1'b1;
					res_ev   = aldk_pkg::EV_RELEASE;
					res_code = held_code_q;
				end
			end
			aldk_pkg::KIND_SAMPLE: begin
				if (!hit_q) begin
					if (miss_nx > aldk_pkg::MISS_LIMIT) begin
						res_load = 1'b1;
						res_ev   = aldk_pkg::EV_RELEARN;
					end
				end else if (streak_nx > 2'd1) begin
					res_load = 1'b1;
					res_ev   = held_q ? aldk_pkg::EV_REPEAT : aldk_pkg::EV_PRESS;
					res_code = hit_code_q;
					res_idx  = 4'(hit_idx_q);
				end
			end
			default: ;
		endcase
	end

	// commit decode state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			streak_vld_q <= 1'b0;
			streak_idx_q <= '0;
			streak_cnt_q <= 2'd0;
			miss_q       <= 4'd0;
			idle_q       <= 8'd0;
			held_q       <= 1'b0;
			held_code_q  <= '0;
			count_q      <= 16'd0;
		end else if (cmd.decide) begin
			case (kind_q)
				aldk_pkg::KIND_TICK: begin
					if (count_q != 16'd0) begin
						count_q <= count_dec;
						if (count_dec == 16'd0) begin
							held_q <= 1'b0;
						end
					end
				end
				aldk_pkg::KIND_SAMPLE: begin
					if (!hit_q) begin
						if (miss_nx > aldk_pkg::MISS_LIMIT) begin
							miss_q <= 4'd0;
							idle_q <= sample_q;
						end else begin
							miss_q <= miss_nx;
						end
					end else begin
						miss_q <= 4'd0;
						if (streak_nx > 2'd1) begin
							streak_vld_q <= 1'b0;
							streak_cnt_q <= 2'd0;
							held_code_q  <= hit_code_q;
							held_q       <= 1'b1;
							count_q      <= rel_eff;
						end else begin
							streak_vld_q <= 1'b1;
							streak_idx_q <= hit_idx_q;
							streak_cnt_q <= streak_nx;
						end
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.decide && res_load) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.decide && res_load) begin
			event_res <= res_ev;
			code_res  <= res_code;
			key_index <= res_idx;
		end
	end

	assign res_valid = res_valid_q;

endmodule

`default_nettype wire

// File: design/adc_ladder_key_decoder_core.sv
// Top level of the ADC ladder key decoder: controller, datapath and port checks.
// Depends on aldk_pkg, aldk_ctrl, aldk_dp and aldk_ram.
`default_nettype none

// Takes one word at a time. A sample is first scaled by a multiply, then divided in
// the bit-serial divider, then the key map RAM is read one entry per cycle until the
// first matching range or the end of the map. A finished result sits in the output
// register while the next word is accepted; a sample or a tick waits at its last step
// until that register is free. Map entries read before they are written return
// undefined codes.
module adc_ladder_key_decoder_core #(
	parameter int MAP_ENTRIES = 16
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_we,
	input  wire logic [1:0]                  cfg_index,
	input  wire logic [aldk_pkg::CFG_W-1:0]  cfg_data,
	input  wire logic                        item_valid,
	output logic                             item_stall,
	input  wire logic [1:0]                  kind,
	input  wire logic [7:0]                  sample,
	input  wire logic [3:0]                  entry_index,
	input  wire logic [aldk_pkg::MV_W-1:0]   entry_min,
	input  wire logic [aldk_pkg::MV_W-1:0]   entry_max,
	input  wire logic [aldk_pkg::CODE_W-1:0] entry_code,
	output logic                             res_valid,
	input  wire logic                        res_stall,
	output logic [1:0]                       event_res,
	output logic [aldk_pkg::CODE_W-1:0]      code_res,
	output logic [3:0]                       key_index
);

	aldk_pkg::cmd_t cmd;
	aldk_pkg::sts_t sts;

	aldk_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_kind  (kind),
		.item_stall (item_stall),
		.cmd        (cmd),
		.sts        (sts)
	);

	aldk_dp #(
		.MAP_ENTRIES (MAP_ENTRIES)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.kind        (kind),
		.sample      (sample),
		.entry_index (entry_index),
		.entry_min   (entry_min),
		.entry_max   (entry_max),
		.entry_code  (entry_code),
		.res_valid   (res_valid),
		.res_stall   (res_stall),
		.event_res   (event_res),
		.code_res    (code_res),
		.key_index   (key_index)
	);

	a_sample_busy: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall && (kind == aldk_pkg::KIND_SAMPLE) |=> item_stall)
		else $error("sample word did not start the scaler");

	a_write_no_wait: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall &&
		((kind == aldk_pkg::KIND_MAP) || (kind == aldk_pkg::KIND_RSVD)) |=> !item_stall)
		else $error("map write or ignored word held the input");

	a_tick_short: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall && (kind == aldk_pkg::KIND_TICK) |=> item_stall)
		else $error("tick word skipped the decide step");

	a_relearn_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (event_res == aldk_pkg::EV_RELEARN) |->
		(code_res == '0) && (key_index == 4'd0))
		else $error("relearn result carries a key");

	a_release_idx: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (event_res == aldk_pkg::EV_RELEASE) |-> (key_index == 4'd0))
		else $error("release result carries an entry index");

endmodule

`default_nettype wire
